// File: rtl/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// shared types, codes and fixed constants of the space-vector duty pipeline
// ----------------------------------------------------------------------------
package svpwm_pkg;

   localparam int PERIOD_BITS   = 16;
   localparam int SECTOR_BITS   = 3;
   localparam int STATUS_BITS   = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   typedef logic [PERIOD_BITS-1:0] period_type;
   typedef logic [SECTOR_BITS-1:0] sector_type;
   typedef logic [STATUS_BITS-1:0] status_type;

   // sqrt(3) with 32 fraction bits, rounded per use to the fraction width
   localparam logic [63:0] SQRT3_Q32 = 64'd7439101574;

   localparam period_type PERIOD_RESET = 16'd4000;

   localparam sector_type SECTOR_1 = 3'd1;
   localparam sector_type SECTOR_2 = 3'd2;
   localparam sector_type SECTOR_3 = 3'd3;
   localparam sector_type SECTOR_4 = 3'd4;
   localparam sector_type SECTOR_5 = 3'd5;
   localparam sector_type SECTOR_6 = 3'd6;

   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_SAT      = 2'd1;
   localparam status_type STATUS_BUS_ZERO = 2'd2;

   // register index taken from the word address
   localparam logic CSR_IDX_PERIOD = 1'b0;

   // per-item control that rides along the pipeline
   typedef struct packed {
      sector_type sector;
      logic       bus_zero;
   } side_type;

endpackage

// File: rtl/svpwm_if.sv
// ----------------------------------------------------------------------------
// svpwm_req_if / svpwm_rsp_if
// valid/ready channels for reference items and duty results
// ----------------------------------------------------------------------------
interface svpwm_req_if #(
   parameter int VOLT_BITS = 16
) ();
   logic                        valid;
   logic                        ready;
   logic signed [VOLT_BITS-1:0] alpha_volt;
   logic signed [VOLT_BITS-1:0] beta_volt;
   logic        [VOLT_BITS-1:0] bus_voltage;

   modport source (output valid, output alpha_volt, output beta_volt,
                   output bus_voltage, input ready);
   modport sink   (input valid, input alpha_volt, input beta_volt,
                   input bus_voltage, output ready);
endinterface

interface svpwm_rsp_if import svpwm_pkg::*; ();
   logic       valid;
   logic       ready;
   period_type duty_a;
   period_type duty_b;
   period_type duty_c;
   sector_type sector_num;
   status_type status;

   modport source (output valid, output duty_a, output duty_b, output duty_c,
                   output sector_num, output status, input ready);
   modport sink   (input valid, input duty_a, input duty_b, input duty_c,
                   input sector_num, input status, output ready);
endinterface

// File: rtl/svpwm_proj.sv
// ----------------------------------------------------------------------------
// svpwm_proj
// two-stage front end: constant products, sector decision, numerators
// ----------------------------------------------------------------------------
module svpwm_proj import svpwm_pkg::*; #(
   parameter int VOLT_BITS = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic signed [VOLT_BITS-1:0] in_alpha,
   input  logic signed [VOLT_BITS-1:0] in_beta,
   input  logic        [VOLT_BITS-1:0] in_bus,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [VOLT_BITS+FRAC_BITS:0] out_num [2],
   output logic        [VOLT_BITS-1:0] out_bus,
   output side_type                    out_side
);

   localparam int V  = VOLT_BITS;
   localparam int F  = FRAC_BITS;
   localparam int NW = V + F + 2;
   localparam int DW = NW - 1;

   localparam logic [63:0] S3_Q  = (SQRT3_Q32 + (64'd1 << (31 - F))) >> (32 - F);
   localparam logic [63:0] S3H_Q = (SQRT3_Q32 + (64'd1 << (32 - F))) >> (33 - F);
   localparam logic [63:0] T2_Q  = 64'd3 << (F - 1);

   localparam logic signed [NW-1:0] S3_S  = NW'(S3_Q);
   localparam logic signed [NW-1:0] S3H_S = NW'(S3H_Q);
   localparam logic signed [NW-1:0] T2_S  = NW'(T2_Q);

   // stage 1 registers
   logic                 s1_vld_ff;
   logic signed [NW-1:0] s1_as_ff, s1_bs_ff, s1_p_ff, s1_q_ff, s1_r_ff;
   logic signed [NW-1:0] s1_as_in, s1_bs_in, s1_p_in, s1_q_in, s1_r_in;
   logic                 s1_bneg_ff, s1_bneg_in;
   logic                 s1_bzero_ff, s1_bzero_in;
   logic [V-1:0]         s1_bus_ff;

   // stage 2 registers
   logic                 s2_vld_ff;
   logic [DW-1:0]        s2_num_ff [2];
   logic [DW-1:0]        s2_num_in [2];
   logic [V-1:0]         s2_bus_ff;
   side_type             s2_side_ff, s2_side_in;

   logic s1_rdy, s2_rdy;

   assign s2_rdy   = !s2_vld_ff || out_ready;
   assign s1_rdy   = !s1_vld_ff || s2_rdy;
   assign in_ready = s1_rdy;

   always_comb begin
      logic signed [NW-1:0] a_ext;
      logic signed [NW-1:0] b_ext;
      a_ext       = NW'(in_alpha);
      b_ext       = NW'(in_beta);
      s1_as_in    = a_ext * S3_S;
      s1_bs_in    = b_ext <<< F;
      s1_p_in     = a_ext * T2_S;
      s1_q_in     = b_ext * S3H_S;
      s1_r_in     = b_ext * S3_S;
      s1_bneg_in  = in_beta[V-1];
      s1_bzero_in = (in_bus == '0);
   end

   // sector from beta/sqrt3 against +alpha and -alpha, then the two numerators
   always_comb begin
      logic signed [NW-1:0] pmq, qmp, ppq, npq, nr;
      logic signed [NW-1:0] n1, n2;
      logic signed [NW-1:0] nas;
      sector_type           sec;
      pmq = s1_p_ff - s1_q_ff;
      qmp = s1_q_ff - s1_p_ff;
      ppq = s1_p_ff + s1_q_ff;
      npq = -ppq;
      nr  = -s1_r_ff;
      nas = -s1_as_ff;
      if (!s1_bneg_ff) begin
         if (s1_bs_ff < s1_as_ff) begin
            sec = SECTOR_1;
         end else if (s1_bs_ff < nas) begin
            sec = SECTOR_3;
         end else begin
            sec = SECTOR_2;
         end
      end else begin
         if (s1_bs_ff > s1_as_ff) begin
            sec = SECTOR_4;
         end else if (s1_bs_ff < nas) begin
            sec = SECTOR_5;
         end else begin
            sec = SECTOR_6;
         end
      end
      case (sec)
         SECTOR_1: begin
            n1 = pmq;
            n2 = s1_r_ff;
         end
         SECTOR_2: begin
            n1 = qmp;
            n2 = ppq;
         end
         SECTOR_3: begin
            n1 = s1_r_ff;
            n2 = npq;
         end
         SECTOR_4: begin
            n1 = nr;
            n2 = qmp;
         end
         SECTOR_5: begin
            n1 = npq;
            n2 = pmq;
         end
         default: begin
            n1 = ppq;
            n2 = nr;
         end
      endcase
      // a negative numerator gives a zero fraction
      s2_num_in[0]        = n1[NW-1] ? '0 : n1[DW-1:0];
      s2_num_in[1]        = n2[NW-1] ? '0 : n2[DW-1:0];
      s2_side_in.sector   = sec;
      s2_side_in.bus_zero = s1_bzero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (s1_rdy) begin
            s1_vld_ff <= in_valid;
         end
         if (s2_rdy) begin
            s2_vld_ff <= s1_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy && in_valid) begin
         s1_as_ff    <= s1_as_in;
         s1_bs_ff    <= s1_bs_in;
         s1_p_ff     <= s1_p_in;
         s1_q_ff     <= s1_q_in;
         s1_r_ff     <= s1_r_in;
         s1_bneg_ff  <= s1_bneg_in;
         s1_bzero_ff <= s1_bzero_in;
         s1_bus_ff   <= in_bus;
      end
      if (s2_rdy && s1_vld_ff) begin
         s2_num_ff  <= s2_num_in;
         s2_bus_ff  <= s1_bus_ff;
         s2_side_ff <= s2_side_in;
      end
   end

   assign out_valid = s2_vld_ff;
   assign out_num   = s2_num_ff;
   assign out_bus   = s2_bus_ff;
   assign out_side  = s2_side_ff;

endmodule

// File: rtl/svpwm_div.sv
// ----------------------------------------------------------------------------
// svpwm_div
// two-lane pipelined restoring divider, one quotient bit per stage,
// quotient saturated to the unsigned fraction range
// ----------------------------------------------------------------------------
module svpwm_div import svpwm_pkg::*; #(
   parameter int VOLT_BITS = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [VOLT_BITS+FRAC_BITS:0]  in_num [2],
   input  logic [VOLT_BITS-1:0]          in_den,
   input  side_type                      in_side,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [FRAC_BITS:0]            out_quo [2],
   output side_type                      out_side
);

   localparam int V     = VOLT_BITS;
   localparam int QB    = FRAC_BITS + 1;
   localparam int DW    = VOLT_BITS + FRAC_BITS + 1;
   localparam int NS    = QB + 1;
   localparam int LANES = 2;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   wire  [NS-1:0] rdy;

   logic [V-1:0]  den_ff  [NS];
   logic [V-1:0]  den_in  [NS];
   side_type      side_ff [NS];
   side_type      side_in [NS];
   logic [V-1:0]  rem_ff  [NS][LANES];
   logic [V-1:0]  rem_in  [NS][LANES];
   logic [QB-1:0] wrk_ff  [NS][LANES];
   logic [QB-1:0] wrk_in  [NS][LANES];
   logic          ovf_ff  [NS][LANES];
   logic          ovf_in  [NS][LANES];

   for (genvar s = 0; s < NS; s++) begin : g_rdy
      if (s == NS - 1) begin : g_last
         assign rdy[s] = !vld_ff[s] || out_ready;
      end else begin : g_mid
         assign rdy[s] = !vld_ff[s] || rdy[s+1];
      end
   end

   assign vld_in   = {vld_ff[NS-2:0], in_valid};
   assign in_ready = rdy[0];

   always_comb begin
      logic [V-1:0] hi;
      logic [V:0]   part;
      logic [V:0]   dext;
      logic         ge;
      // entry: quotient overflows when the upper dividend part reaches the divisor
      den_in[0]  = in_den;
      side_in[0] = in_side;
      for (int l = 0; l < LANES; l++) begin
         hi           = in_num[l][DW-1:QB];
         ovf_in[0][l] = (hi >= in_den);
         rem_in[0][l] = ovf_in[0][l] ? '0 : hi;
         wrk_in[0][l] = in_num[l][QB-1:0];
      end
      // each step brings down one dividend bit and shifts in one quotient bit
      for (int s = 1; s < NS; s++) begin
         den_in[s]  = den_ff[s-1];
         side_in[s] = side_ff[s-1];
         dext       = {1'b0, den_ff[s-1]};
         for (int l = 0; l < LANES; l++) begin
            part         = {rem_ff[s-1][l], wrk_ff[s-1][l][QB-1]};
            ge           = (part >= dext);
            rem_in[s][l] = ge ? V'(part - dext) : part[V-1:0];
            wrk_in[s][l] = {wrk_ff[s-1][l][QB-2:0], ge};
            ovf_in[s][l] = ovf_ff[s-1][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (rdy[s]) begin
               vld_ff[s] <= vld_in[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NS; s++) begin
         if (rdy[s] && vld_in[s]) begin
            den_ff[s]  <= den_in[s];
            side_ff[s] <= side_in[s];
            rem_ff[s]  <= rem_in[s];
            wrk_ff[s]  <= wrk_in[s];
            ovf_ff[s]  <= ovf_in[s];
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_side  = side_ff[NS-1];
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quo[l] = ovf_ff[NS-1][l] ? '1 : wrk_ff[NS-1][l];
      end
   end

endmodule

// File: rtl/svpwm_duty.sv
// ----------------------------------------------------------------------------
// svpwm_duty
// three-stage back end: switching times, period scaling, rounding,
// saturation and phase ordering into the output register
// ----------------------------------------------------------------------------
module svpwm_duty import svpwm_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [FRAC_BITS:0] in_frac [2],
   input  side_type           in_side,
   input  period_type         period,
   output logic               out_valid,
   input  logic               out_ready,
   output period_type         out_duty_a,
   output period_type         out_duty_b,
   output period_type         out_duty_c,
   output sector_type         out_sector,
   output status_type         out_status
);

   localparam int F   = FRAC_BITS;
   localparam int TW  = F + 4;
   localparam int MW  = F + 3;
   localparam int PW  = MW + PERIOD_BITS;
   localparam int PW1 = PW + 1;
   localparam int RW  = PW - F;

   localparam int IDX_LO  = 0;
   localparam int IDX_MID = 1;
   localparam int IDX_HI  = 2;

   localparam logic signed [TW-1:0] ONE_T    = TW'(64'd1 << F);
   localparam logic        [PW:0]   HALF_LSB = PW1'(64'd1 << F);

   logic s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic s1_rdy, s2_rdy, s3_rdy;

   logic signed [TW-1:0] t_ff [3];
   logic signed [TW-1:0] t_in [3];
   side_type             s1_side_ff;

   logic [PW-1:0] prod_ff [3];
   logic [PW-1:0] prod_in [3];
   logic          neg_ff  [3];
   logic          neg_in  [3];
   side_type      s2_side_ff;

   period_type duty_v [3];
   period_type duty_a_ff, duty_b_ff, duty_c_ff;
   period_type duty_a_in, duty_b_in, duty_c_in;
   sector_type sector_ff;
   status_type status_ff, status_in;

   assign s3_rdy   = !s3_vld_ff || out_ready;
   assign s2_rdy   = !s2_vld_ff || s3_rdy;
   assign s1_rdy   = !s1_vld_ff || s2_rdy;
   assign in_ready = s1_rdy;

   // lo = d0, mid = d0 + 2*d2, hi = d0 + 2*d1 + 2*d2 with d0 = 1 - d1 - d2
   always_comb begin
      logic signed [TW-1:0] d1;
      logic signed [TW-1:0] d2;
      d1             = $signed({3'b000, in_frac[0]});
      d2             = $signed({3'b000, in_frac[1]});
      t_in[IDX_LO]   = ONE_T - d1 - d2;
      t_in[IDX_MID]  = ONE_T - d1 + d2;
      t_in[IDX_HI]   = ONE_T + d1 + d2;
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         neg_in[k]  = t_ff[k][TW-1];
         prod_in[k] = PW'(t_ff[k][MW-1:0]) * PW'(period);
      end
   end

   always_comb begin
      logic [PW:0]   rnd;
      logic [RW-1:0] dq;
      logic          over;
      logic          sat;
      sat = 1'b0;
      for (int k = 0; k < 3; k++) begin
         rnd  = PW1'(prod_ff[k]) + HALF_LSB;
         dq   = rnd[PW:F+1];
         over = (dq > RW'(period));
         sat  = sat | neg_ff[k] | over;
         if (neg_ff[k]) begin
            duty_v[k] = '0;
         end else if (over) begin
            duty_v[k] = period;
         end else begin
            duty_v[k] = dq[PERIOD_BITS-1:0];
         end
      end
      case (s2_side_ff.sector)
         SECTOR_1: begin
            duty_a_in = duty_v[IDX_HI];
            duty_b_in = duty_v[IDX_MID];
            duty_c_in = duty_v[IDX_LO];
         end
         SECTOR_2: begin
            duty_a_in = duty_v[IDX_MID];
            duty_b_in = duty_v[IDX_HI];
            duty_c_in = duty_v[IDX_LO];
         end
         SECTOR_3: begin
            duty_a_in = duty_v[IDX_LO];
            duty_b_in = duty_v[IDX_HI];
            duty_c_in = duty_v[IDX_MID];
         end
         SECTOR_4: begin
            duty_a_in = duty_v[IDX_LO];
            duty_b_in = duty_v[IDX_MID];
            duty_c_in = duty_v[IDX_HI];
         end
         SECTOR_5: begin
            duty_a_in = duty_v[IDX_MID];
            duty_b_in = duty_v[IDX_LO];
            duty_c_in = duty_v[IDX_HI];
         end
         default: begin
            duty_a_in = duty_v[IDX_HI];
            duty_b_in = duty_v[IDX_LO];
            duty_c_in = duty_v[IDX_MID];
         end
      endcase
      status_in = sat ? STATUS_SAT : STATUS_OK;
      // dead bus: all phases at half period
      if (s2_side_ff.bus_zero) begin
         duty_a_in = period >> 1;
         duty_b_in = period >> 1;
         duty_c_in = period >> 1;
         status_in = STATUS_BUS_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         if (s1_rdy) begin
            s1_vld_ff <= in_valid;
         end
         if (s2_rdy) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (s3_rdy) begin
            s3_vld_ff <= s2_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy && in_valid) begin
         t_ff       <= t_in;
         s1_side_ff <= in_side;
      end
      if (s2_rdy && s1_vld_ff) begin
         prod_ff    <= prod_in;
         neg_ff     <= neg_in;
         s2_side_ff <= s1_side_ff;
      end
      if (s3_rdy && s2_vld_ff) begin
         duty_a_ff <= duty_a_in;
         duty_b_ff <= duty_b_in;
         duty_c_ff <= duty_c_in;
         sector_ff <= s2_side_ff.sector;
         status_ff <= status_in;
      end
   end

   assign out_valid  = s3_vld_ff;
   assign out_duty_a = duty_a_ff;
   assign out_duty_b = duty_b_ff;
   assign out_duty_c = duty_c_ff;
   assign out_sector = sector_ff;
   assign out_status = status_ff;

endmodule

// File: rtl/svpwm_duty_from_alpha_beta.sv
// throughput: one item per cycle while the output is not stalled, every stage holds its own valid bit
// the two-lane divider sets the depth, one quotient bit per stage
// a stalled result holds in the output register while bubbles upstream still fill
// synchronous reset empties the pipeline and loads the period register with 4000
// ----------------------------------------------------------------------------
// svpwm_duty_from_alpha_beta
// space-vector pwm compare counts from an alpha-beta voltage reference
// ----------------------------------------------------------------------------
module svpwm_duty_from_alpha_beta import svpwm_pkg::*; #(
   parameter int VOLT_BITS = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   svpwm_req_if.sink                req_ch,
   svpwm_rsp_if.source              rsp_ch,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int V  = VOLT_BITS;
   localparam int DW = VOLT_BITS + FRAC_BITS + 1;
   localparam int QB = FRAC_BITS + 1;

   // ---- configuration register ----
   period_type period_ff;
   period_type period_in;
   logic       csr_idx;
   logic       csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_BITS-1];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      period_in = period_ff;
      if (csr_wr && (csr_idx == CSR_IDX_PERIOD)) begin
         period_in = pwdata[PERIOD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else begin
         period_ff <= period_in;
      end
   end

   // reads of unknown indexes return zero
   assign prdata = (csr_idx == CSR_IDX_PERIOD) ? CSR_DATA_BITS'(period_ff) : '0;

   // ---- front end: products, sector, numerators (2 stages) ----
   logic          pj_valid, pj_ready;
   logic [DW-1:0] pj_num [2];
   logic [V-1:0]  pj_bus;
   side_type      pj_side;

   svpwm_proj #(
      .VOLT_BITS (VOLT_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_proj (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_alpha  (V'(req_ch.alpha_volt)),
      .in_beta   (V'(req_ch.beta_volt)),
      .in_bus    (V'(req_ch.bus_voltage)),
      .out_valid (pj_valid),
      .out_ready (pj_ready),
      .out_num   (pj_num),
      .out_bus   (pj_bus),
      .out_side  (pj_side)
   );

   // ---- divider: both fractions over the bus voltage (FRAC_BITS + 2 stages) ----
   logic          dv_valid, dv_ready;
   logic [QB-1:0] dv_quo [2];
   side_type      dv_side;

   svpwm_div #(
      .VOLT_BITS (VOLT_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pj_valid),
      .in_ready  (pj_ready),
      .in_num    (pj_num),
      .in_den    (pj_bus),
      .in_side   (pj_side),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // ---- back end: times, scaling, saturation, phase order (3 stages) ----
   // the last stage is the result register seen on the output channel
   svpwm_duty #(
      .FRAC_BITS (FRAC_BITS)
   ) u_duty (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (dv_valid),
      .in_ready   (dv_ready),
      .in_frac    (dv_quo),
      .in_side    (dv_side),
      .period     (period_ff),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_duty_a (rsp_ch.duty_a),
      .out_duty_b (rsp_ch.duty_b),
      .out_duty_c (rsp_ch.duty_c),
      .out_sector (rsp_ch.sector_num),
      .out_status (rsp_ch.status)
   );

endmodule

// File: rtl/svpwm_check.sv
// ----------------------------------------------------------------------------
// svpwm_check
// port-level checks of the duty pipeline, bound to the top level
// ----------------------------------------------------------------------------
module svpwm_check import svpwm_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input period_type duty_a,
   input period_type duty_b,
   input period_type duty_c,
   input sector_type sector_num,
   input status_type status
);

   logic [7:0] pend_ff;
   logic [7:0] pend_in;

   // items taken in and not yet delivered
   always_comb begin
      pend_in = pend_ff;
      if (req_valid && req_ready) begin
         pend_in = pend_in + 8'd1;
      end
      if (rsp_valid && rsp_ready) begin
         pend_in = pend_in - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 8'd0)
      else $error("result without a pending item");

   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (sector_num >= SECTOR_1) && (sector_num <= SECTOR_6))
      else $error("sector out of range");

   a_bus_zero_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == STATUS_BUS_ZERO) |->
         (duty_a == duty_b) && (duty_b == duty_c))
      else $error("unequal duties on dead bus");

   a_sector1_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != STATUS_BUS_ZERO) && (sector_num == SECTOR_1) |->
         (duty_a >= duty_b) && (duty_b >= duty_c))
      else $error("phase order broken in sector 1");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(duty_a) && $stable(duty_b)
         && $stable(duty_c) && $stable(sector_num) && $stable(status))
      else $error("stalled result changed");

endmodule

bind svpwm_duty_from_alpha_beta svpwm_check u_svpwm_check (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .duty_a     (rsp_ch.duty_a),
   .duty_b     (rsp_ch.duty_b),
   .duty_c     (rsp_ch.duty_c),
   .sector_num (rsp_ch.sector_num),
   .status     (rsp_ch.status)
);
